// File: hdl/static_doubly_linked_list_top_macros.svh
// Assertion macros shared by the checker
`ifndef STATIC_DOUBLY_LINKED_LIST_TOP_MACROS_SVH
`define STATIC_DOUBLY_LINKED_LIST_TOP_MACROS_SVH
`define SDLL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SDLL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: hdl/sdll_pkg.sv
// Package: constants, codes and types of the linked list block
package sdll_pkg;
	localparam int ENTRIES_DEF = 16;
	localparam int MAX_OUT = 16;

	typedef enum logic [3:0] {
		OP_ADD_FIRST = 4'd0, OP_ADD_AFTER = 4'd1, OP_ADD_LAST = 4'd2,
		OP_DEL_FIRST = 4'd3, OP_DEL_AFTER = 4'd4, OP_DEL_LAST = 4'd5,
		OP_CLEAR = 4'd6, OP_WALK_FWD = 4'd7, OP_WALK_REV = 4'd8
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_FULL = 2'd1, ST_EMPTY = 2'd2, ST_BAD = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_EXEC, S_FIX, S_WALK_RD, S_WALK_EMIT, S_OUT
	} state_t;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [3:0]  anchor_slot;
		logic [31:0] kind_code;
		logic [63:0] plate_code;
		logic [15:0] year;
		logic [63:0] owner_code;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  result_slot;
		logic [4:0]  element_total;
		logic [31:0] out_kind;
		logic [63:0] out_plate;
		logic [15:0] out_year;
		logic [63:0] out_owner;
		logic        last_result;
	} rsp_t;
endpackage

// File: hdl/sdll_if.sv
// Valid/ready channel interface carrying one payload
interface sdll_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/static_doubly_linked_list_top.sv
// Top level: array-backed doubly linked list with record and link memories
// Usage:
//  Requests enter on req (valid/ready, sdll_pkg::req_t payload), results leave on rsp
//  (sdll_pkg::rsp_t). One request is handled at a time; req.ready is high only while
//  the sequencer is idle. A result still waiting in the output register does not
//  block the next request, which runs up to its result stage and waits there.
//  Delete first/last, clear and rejected inserts pass read (links), exec (decide
//  and write) and out (present the result); insert and delete after also pass fix
//  between exec and out, patching a neighbor link.
//  A walk reads link and record, then presents, for each element in turn, and reads
//  the next element only once the result is loaded; at most 16 results.
//  An unused opcode gives no result; req.ready returns after its read state.
//  A new request can be accepted in the cycle after the previous result is loaded.
//  The free slot is found by a priority search over the used-bit flip-flops.
//  Reset clears the used bits, head, tail and count; the record and link memories
//  keep whatever they hold and are only read for used slots.
//  When rsp.ready is low, the result waits in its register and the sequencer holds;
//  nothing is lost or repeated.
module static_doubly_linked_list_top #(
	parameter int ENTRIES = sdll_pkg::ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	sdll_if.sink   req,
	sdll_if.source rsp
);
	localparam int IW = $clog2(ENTRIES);
	localparam int PW = IW + 1;
	localparam logic [PW-1:0] NIL = PW'(ENTRIES);

	// memories
	logic [31:0]   kind_mem  [ENTRIES];
	logic [63:0]   plate_mem [ENTRIES];
	logic [15:0]   year_mem  [ENTRIES];
	logic [63:0]   owner_mem [ENTRIES];
	logic [PW-1:0] next_mem  [ENTRIES];
	logic [PW-1:0] prev_mem  [ENTRIES];

	logic [ENTRIES-1:0] used_q;
	logic [PW-1:0] head_q, tail_q;
	logic [PW:0]   size_q;

	sdll_pkg::state_t state_q, state_d;
	sdll_pkg::req_t   req_q;
	sdll_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;

	// link memory read port (registered)
	logic [IW-1:0] lrd_addr;
	logic [PW-1:0] nxt_rd, prv_rd;
	// record read
	logic [31:0] kind_rd; logic [63:0] plate_rd, owner_rd; logic [15:0] year_rd;

	// link memory write ports: one for next, one for prev
	logic          nw_en, pw_en;
	logic [IW-1:0] nw_addr, pw_addr;
	logic [PW-1:0] nw_data, pw_data;
	logic          rec_we;
	logic [IW-1:0] rec_addr;

	// working registers
	logic [PW-1:0] cur_q;      // target slot / walk position
	logic [PW-1:0] fix_q;      // neighbor needing a back-link patch
	logic [PW-1:0] fixv_q;
	logic          fix_prev_q; // patch prev (1) or next (0)
	logic [4:0]    cnt_q;
	logic [1:0]    ex_st_q;    // status held until the result stage
	logic          ex_ins_q;
	logic [PW-1:0] after_q;

	// free slot search
	logic [PW-1:0] free_slot;
	always_comb begin
		free_slot = NIL;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!used_q[i]) free_slot = PW'(i);
		end
	end

	logic [3:0] op;
	assign op = req_q.opcode;
	logic anc_in, anc_ok;
	assign anc_in = ({1'b0, req_q.anchor_slot} < 5'(ENTRIES)) || (ENTRIES > 16);
	assign anc_ok = anc_in && used_q[IW'(req_q.anchor_slot)];
	logic full;
	assign full = size_q >= (PW+1)'(ENTRIES);

	assign req.ready = (state_q == sdll_pkg::S_IDLE);
	logic acc;
	assign acc = req.valid && req.ready;
	logic rsp_free;
	assign rsp_free = !rsp_valid_q || rsp.ready;
	logic rsp_load;
	assign rsp_load = rsp_free
		&& (state_q == sdll_pkg::S_OUT || state_q == sdll_pkg::S_WALK_EMIT);

	always_ff @(posedge clk) begin
		if (nw_en) next_mem[nw_addr] <= nw_data;
		if (pw_en) prev_mem[pw_addr] <= pw_data;
		nxt_rd <= next_mem[lrd_addr];
		prv_rd <= prev_mem[lrd_addr];
		if (rec_we) begin
			kind_mem[rec_addr]  <= req_q.kind_code;
			plate_mem[rec_addr] <= req_q.plate_code;
			year_mem[rec_addr]  <= req_q.year;
			owner_mem[rec_addr] <= req_q.owner_code;
		end
		kind_rd  <= kind_mem[lrd_addr];
		plate_rd <= plate_mem[lrd_addr];
		year_rd  <= year_mem[lrd_addr];
		owner_rd <= owner_mem[lrd_addr];
	end

	// read address: walk position for walks, otherwise anchor / head / tail; delete after then reads its target
	logic [PW-1:0] rd_sel;
	always_comb begin
		case (op)
			sdll_pkg::OP_ADD_AFTER, sdll_pkg::OP_DEL_AFTER: rd_sel = PW'(req_q.anchor_slot);
			sdll_pkg::OP_DEL_FIRST: rd_sel = head_q;
			sdll_pkg::OP_DEL_LAST, sdll_pkg::OP_ADD_LAST: rd_sel = tail_q;
			default: rd_sel = cur_q;
		endcase
		if (state_q == sdll_pkg::S_EXEC && op == sdll_pkg::OP_DEL_AFTER)
			rd_sel = nxt_rd;
		if (state_q == sdll_pkg::S_WALK_RD || state_q == sdll_pkg::S_WALK_EMIT)
			rd_sel = cur_q;
	end
	assign lrd_addr = rd_sel[IW-1:0];

	// walk termination from link read in EMIT
	logic [PW-1:0] walk_nx;
	logic walk_last;
	assign walk_nx = (op == sdll_pkg::OP_WALK_FWD) ? nxt_rd : prv_rd;
	assign walk_last = (walk_nx == NIL) || (cnt_q == 5'(sdll_pkg::MAX_OUT - 1))
		|| (32'(cnt_q) == 32'(ENTRIES - 1));

	// decision made in S_EXEC (link data for anchor/end valid)
	logic [1:0]    ex_st;
	logic [PW-1:0] ex_slot;
	logic          ex_ins, ex_del;
	logic [PW-1:0] ex_after, ex_tgt;
	always_comb begin
		ex_st = sdll_pkg::ST_OK; ex_slot = '0; ex_ins = 1'b0; ex_del = 1'b0;
		ex_after = NIL; ex_tgt = NIL;
		case (op)
			sdll_pkg::OP_ADD_FIRST, sdll_pkg::OP_ADD_AFTER, sdll_pkg::OP_ADD_LAST: begin
				if (full) ex_st = sdll_pkg::ST_FULL;
				else if (op == sdll_pkg::OP_ADD_AFTER && !anc_ok) ex_st = sdll_pkg::ST_BAD;
				else begin
					ex_ins = 1'b1; ex_slot = free_slot;
					ex_after = (op == sdll_pkg::OP_ADD_FIRST) ? NIL
						: (op == sdll_pkg::OP_ADD_AFTER) ? PW'(req_q.anchor_slot) : tail_q;
				end
			end
			sdll_pkg::OP_DEL_FIRST, sdll_pkg::OP_DEL_LAST: begin
				ex_tgt = (op == sdll_pkg::OP_DEL_FIRST) ? head_q : tail_q;
				if (ex_tgt == NIL) ex_st = sdll_pkg::ST_EMPTY;
				else begin ex_del = 1'b1; ex_slot = ex_tgt; end
			end
			sdll_pkg::OP_DEL_AFTER: begin
				if (!anc_ok || nxt_rd == NIL) ex_st = sdll_pkg::ST_BAD;
				else begin ex_del = 1'b1; ex_slot = nxt_rd; ex_tgt = nxt_rd; end
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sdll_pkg::S_IDLE: if (acc) state_d = sdll_pkg::S_RD;
			sdll_pkg::S_RD: begin
				if (op > sdll_pkg::OP_WALK_REV) state_d = sdll_pkg::S_IDLE;
				else if (op == sdll_pkg::OP_WALK_FWD || op == sdll_pkg::OP_WALK_REV)
					state_d = sdll_pkg::S_WALK_RD;
				else state_d = sdll_pkg::S_EXEC;
			end
			// inserts and delete after patch the neighbor links in S_FIX, the next state
			sdll_pkg::S_EXEC: state_d = (ex_ins || op == sdll_pkg::OP_DEL_AFTER)
				? sdll_pkg::S_FIX : sdll_pkg::S_OUT;
			sdll_pkg::S_FIX: state_d = sdll_pkg::S_OUT;
			sdll_pkg::S_WALK_RD: state_d = sdll_pkg::S_WALK_EMIT;
			sdll_pkg::S_WALK_EMIT: if (rsp_free) begin
				if (cur_q == NIL || walk_last) state_d = sdll_pkg::S_IDLE;
				else state_d = sdll_pkg::S_WALK_RD;
			end
			sdll_pkg::S_OUT: if (rsp_free) state_d = sdll_pkg::S_IDLE;
			default: state_d = sdll_pkg::S_IDLE;
		endcase
	end

	// memory writes
	always_comb begin
		nw_en = 1'b0; pw_en = 1'b0; nw_addr = '0; pw_addr = '0;
		nw_data = NIL; pw_data = NIL; rec_we = 1'b0; rec_addr = free_slot[IW-1:0];
		if (state_q == sdll_pkg::S_EXEC && ex_ins) begin
			// new slot: next = successor, prev = after; predecessor.next = new is written in S_FIX
			rec_we = 1'b1;
			nw_en = 1'b1; nw_addr = free_slot[IW-1:0];
			nw_data = (ex_after == NIL) ? head_q : nxt_rd;
			pw_en = 1'b1; pw_addr = free_slot[IW-1:0]; pw_data = ex_after;
		end else if (state_q == sdll_pkg::S_EXEC && ex_del && op != sdll_pkg::OP_DEL_AFTER) begin
			// target links are in nxt_rd/prv_rd
			if (prv_rd != NIL) begin nw_en = 1'b1; nw_addr = prv_rd[IW-1:0]; nw_data = nxt_rd; end
			if (nxt_rd != NIL) begin pw_en = 1'b1; pw_addr = nxt_rd[IW-1:0]; pw_data = prv_rd; end
		end else if (state_q == sdll_pkg::S_FIX) begin
			if (fix_prev_q) begin
				if (fix_q != NIL) begin
					pw_en = 1'b1; pw_addr = fix_q[IW-1:0]; pw_data = fixv_q;
				end
			end else begin
				// delete after: target links now read in nxt_rd (target.next)
				nw_en = 1'b1; nw_addr = req_q.anchor_slot[IW-1:0]; nw_data = nxt_rd;
				if (nxt_rd != NIL) begin
					pw_en = 1'b1; pw_addr = nxt_rd[IW-1:0]; pw_data = PW'(req_q.anchor_slot);
				end
			end
		end
		if (state_q == sdll_pkg::S_FIX && fix_prev_q && ex_ins_q) begin
			if (after_q != NIL) begin
				nw_en = 1'b1; nw_addr = after_q[IW-1:0]; nw_data = cur_q;
			end
		end
	end

	// control and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdll_pkg::S_IDLE;
			used_q <= '0; head_q <= NIL; tail_q <= NIL; size_q <= '0;
			rsp_valid_q <= 1'b0; cnt_q <= '0; fix_prev_q <= 1'b0; ex_ins_q <= 1'b0;
			rsp_q <= '0; cur_q <= NIL; fix_q <= NIL; fixv_q <= NIL; after_q <= NIL;
			ex_st_q <= sdll_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
			case (state_q)
				sdll_pkg::S_IDLE: if (acc) begin
					cnt_q <= '0; ex_ins_q <= 1'b0;
				end
				sdll_pkg::S_RD: begin
					cur_q <= (op == sdll_pkg::OP_WALK_FWD) ? head_q : tail_q;
					if (op == sdll_pkg::OP_CLEAR) begin
						used_q <= '0; head_q <= NIL; tail_q <= NIL; size_q <= '0;
					end
				end
				sdll_pkg::S_EXEC: begin
					ex_st_q <= ex_st;
					cur_q <= ex_slot; after_q <= ex_after; ex_ins_q <= ex_ins;
					fix_prev_q <= 1'b1; fix_q <= NIL;
					if (ex_ins) begin
						used_q[free_slot[IW-1:0]] <= 1'b1;
						size_q <= size_q + 1'b1;
						if (ex_after == NIL) head_q <= free_slot;
						// successor back-link patched in S_FIX
						fix_q <= (ex_after == NIL) ? head_q : nxt_rd;
						fixv_q <= free_slot;
						if (((ex_after == NIL) ? head_q : nxt_rd) == NIL) tail_q <= free_slot;
					end
					if (ex_del) begin
						used_q[ex_slot[IW-1:0]] <= 1'b0;
						size_q <= size_q - 1'b1;
						if (op == sdll_pkg::OP_DEL_AFTER) fix_prev_q <= 1'b0;
						else begin
							if (prv_rd == NIL) head_q <= nxt_rd;
							if (nxt_rd == NIL) tail_q <= prv_rd;
						end
					end
				end
				sdll_pkg::S_FIX: begin
					if (!fix_prev_q && nxt_rd == NIL) tail_q <= PW'(req_q.anchor_slot);
				end
				sdll_pkg::S_WALK_EMIT: if (rsp_free) begin
					rsp_q.status <= (cur_q == NIL) ? sdll_pkg::ST_EMPTY : sdll_pkg::ST_OK;
					rsp_q.result_slot <= (cur_q == NIL) ? 4'd0 : 4'(cur_q);
					rsp_q.element_total <= 5'(size_q);
					rsp_q.out_kind <= (cur_q == NIL) ? '0 : kind_rd;
					rsp_q.out_plate <= (cur_q == NIL) ? '0 : plate_rd;
					rsp_q.out_year <= (cur_q == NIL) ? '0 : year_rd;
					rsp_q.out_owner <= (cur_q == NIL) ? '0 : owner_rd;
					rsp_q.last_result <= (cur_q == NIL) || walk_last;
					cur_q <= walk_nx; cnt_q <= cnt_q + 1'b1;
				end
				sdll_pkg::S_OUT: if (rsp_free) begin
					rsp_q.status <= ex_st_q;
					rsp_q.result_slot <= 4'(cur_q);
					rsp_q.element_total <= 5'(size_q);
					rsp_q.out_kind <= '0; rsp_q.out_plate <= '0;
					rsp_q.out_year <= '0; rsp_q.out_owner <= '0;
					rsp_q.last_result <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = rsp_q;

	always_ff @(posedge clk) begin
		if (acc) req_q <= req.payload;
	end
endmodule

// File: hdl/sdll_checker.sv
// Port-level checker for the linked list top level, with its bind
`include "static_doubly_linked_list_top_macros.svh"
module sdll_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input sdll_pkg::rsp_t rsp_payload
);
	logic stall, fail_st, total_ok, took;
	assign stall = rsp_valid && !rsp_ready;
	// a rejected or empty request always gives a single result
	assign fail_st = rsp_valid && (rsp_payload.status != sdll_pkg::ST_OK);
	assign total_ok = rsp_payload.element_total <= 5'(sdll_pkg::ENTRIES_DEF);
	assign took = req_valid && req_ready;

	`SDLL_ASSERT_NXT(a_rsp_hold, clk, arst_n, stall, rsp_valid && $stable(rsp_payload), "rsp moved")
	`SDLL_ASSERT_IMP(a_fail_single, clk, arst_n, fail_st, rsp_payload.last_result, "fail not last")
	`SDLL_ASSERT_IMP(a_total_range, clk, arst_n, rsp_valid, total_ok, "element total out of range")
	`SDLL_ASSERT_NXT(a_one_at_a_time, clk, arst_n, took, !req_ready, "second request taken too soon")
endmodule

bind static_doubly_linked_list_top sdll_checker u_sdll_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);
